// ----- design/tlvtf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TLV tag finder package
// Field widths, result status codes, register indexes and register reset
// values shared by the tag finder and its result channel interface.
// ----------------------------------------------------------------------------
package tlvtf_pkg;

    localparam int STATUS_W = 3;
    localparam int OFFS_W   = 16;
    localparam int LEN_W    = 16;
    localparam int ID_W     = 16;
    localparam int WORD_W   = 32;
    localparam int BLOB_W   = 17;
    localparam int ADDR_W   = 3;

    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [ADDR_W-1:0]   t_cfg_addr;

    // Search outcome codes.
    localparam t_status ST_FOUND   = 3'd0;
    localparam t_status ST_BAD_HDR = 3'd1;
    localparam t_status ST_TERM    = 3'd2;
    localparam t_status ST_OVERRUN = 3'd3;
    localparam t_status ST_END     = 3'd4;

    // Register indexes on the write port.
    localparam t_cfg_addr CFG_MAGIC_PLAIN   = 3'd0;
    localparam t_cfg_addr CFG_MAGIC_PACKED  = 3'd1;
    localparam t_cfg_addr CFG_MAGIC_ALIGNED = 3'd2;
    localparam t_cfg_addr CFG_MAGIC_CRC     = 3'd3;
    localparam t_cfg_addr CFG_END_ID        = 3'd4;
    localparam t_cfg_addr CFG_WANTED_ID     = 3'd5;
    localparam t_cfg_addr CFG_BLOB_LEN      = 3'd6;

    // Register reset values.
    localparam logic [WORD_W-1:0] RST_MAGIC_PLAIN   = 32'h6472_6148;
    localparam logic [WORD_W-1:0] RST_MAGIC_PACKED  = 32'h524F_5A4C;
    localparam logic [WORD_W-1:0] RST_MAGIC_ALIGNED = 32'h0045_5244;
    localparam logic [WORD_W-1:0] RST_MAGIC_CRC     = 32'h7466_6F53;
    localparam logic [ID_W-1:0]   RST_END_ID        = 16'd0;
    localparam logic [ID_W-1:0]   RST_WANTED_ID     = 16'd0;
    localparam logic [BLOB_W-1:0] RST_BLOB_LEN      = 17'h1_0000;

    // Byte counts of the fixed header words.
    localparam logic [LEN_W-1:0] WORD_BYTES = 16'd4;
    localparam int               CRC_HDR_BYTES = 8;

endpackage
`default_nettype wire

// ----- design/tlvtf_byte_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TLV tag finder byte channel
// Valid/ready stream that carries one blob byte and its start-of-blob flag.
// ----------------------------------------------------------------------------
interface tlvtf_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);

endinterface
`default_nettype wire

// ----- design/tlvtf_res_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TLV tag finder result channel
// Valid/ready stream that carries the outcome of one tag search.
// ----------------------------------------------------------------------------
interface tlvtf_res_if
    import tlvtf_pkg::*;
();

    logic              valid;
    logic              ready;
    t_status           search_status;
    logic [OFFS_W-1:0] body_offset;
    logic [LEN_W-1:0]  body_length;

    modport source (output valid, output search_status, output body_offset,
                    output body_length, input ready);
    modport sink   (input valid, input search_status, input body_offset,
                    input body_length, output ready);

endinterface
`default_nettype wire

// ----- design/tlv_tag_finder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TLV tag finder
// Walks a configuration blob byte by byte, checks its magic word, then
// follows the id/length headers until the wanted tag, the end marker, an
// overrun or the end of the blob settles the search.
// ----------------------------------------------------------------------------
// Usage:
//   Blob bytes enter on i_in in address order; first_byte marks byte zero and
//   restarts the search. Each search gives exactly one transaction on o_res,
//   and bytes after it are dropped until the next first_byte.
//   Registers are to be written through i_cfg_we/i_cfg_addr/i_cfg_data only
//   while the block is idle; the block itself does not enforce this.
// Timing:
//   One byte is accepted per cycle unless a result waiting on o_res stalls
//   the input. A byte is parsed while it sits in the input register, and the
//   result it settles is registered in the result register when the byte is
//   processed; it reaches o_res from there. The parse state update (one
//   saturating subtract and compare on the byte position) sets the rate.
// Reset and stall:
//   Reset restores the register defaults and starts in the magic phase, so a
//   first byte without the start flag still begins a blob. While a result
//   waits on o_res, one further byte is held in the input register; the
//   input then stalls until the result transaction completes.
// ----------------------------------------------------------------------------
module tlv_tag_finder_top
    import tlvtf_pkg::*;
#(
    parameter int MAX_BLOB_BYTES = 65536
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire  [ADDR_W-1:0] i_cfg_addr,
    input  wire  [WORD_W-1:0] i_cfg_data,
    tlvtf_byte_if.sink        i_in,
    tlvtf_res_if.source       o_res
);

    localparam int POS_W = $clog2(MAX_BLOB_BYTES + 1);
    localparam int CMP_W = ((POS_W > BLOB_W) ? POS_W : BLOB_W) + 1;
    localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_BLOB_BYTES);

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_CRC,
        PH_HEADER,
        PH_SKIP,
        PH_DONE
    } t_phase;

    // Configuration registers.
    logic [WORD_W-1:0] r_magic_plain, r_magic_packed, r_magic_aligned, r_magic_crc;
    logic [ID_W-1:0]   r_end_id, r_wanted_id;
    logic [BLOB_W-1:0] r_blob_len;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_first;

    // Parse state.
    t_phase            r_phase, n_phase;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [WORD_W-1:0] r_word, n_word;
    logic [LEN_W-1:0]  r_skip, n_skip;
    logic              r_pad, n_pad;

    // Result register.
    logic              r_out_valid;
    t_status           r_status, n_status;
    logic [OFFS_W-1:0] r_offset, n_offset;
    logic [LEN_W-1:0]  r_length, n_length;
    logic              n_emit;

    logic w_adv, w_in_ready, w_proc;

    // Current state after an optional restart.
    t_phase            c_phase;
    logic [POS_W-1:0]  c_pos;
    logic [WORD_W-1:0] c_word;
    logic [LEN_W-1:0]  c_skip;
    logic              c_pad;

    logic [CMP_W-1:0]  w_blob_ext, w_eff, w_pos_inc, w_left;
    logic [WORD_W-1:0] w_shift;
    logic [LEN_W-1:0]  w_skip_dec, w_len, w_len_pad;
    logic [ID_W-1:0]   w_id;
    logic              w_hdr_end;

    assign w_adv      = !r_out_valid || o_res.ready;
    assign w_in_ready = !r_in_valid || w_adv;
    assign w_proc     = r_in_valid && w_adv;
    assign i_in.ready = w_in_ready;

    assign c_phase = r_first ? PH_MAGIC : r_phase;
    assign c_pos   = r_first ? '0 : r_pos;
    assign c_word  = r_first ? '0 : r_word;
    assign c_skip  = r_first ? WORD_BYTES : r_skip;
    assign c_pad   = r_first ? 1'b0 : r_pad;

    assign w_blob_ext = {{(CMP_W-BLOB_W){1'b0}}, r_blob_len};
    assign w_eff      = (w_blob_ext > MAX_LEN) ? MAX_LEN : w_blob_ext;
    assign w_pos_inc  = {{(CMP_W-POS_W){1'b0}}, c_pos} + CMP_W'(1);
    // Bytes still in the blob once this byte is consumed; zero if passed.
    assign w_left     = (w_eff > w_pos_inc) ? (w_eff - w_pos_inc) : '0;
    assign w_hdr_end  = (w_left <= CMP_W'(WORD_BYTES));

    assign w_shift    = {r_byte, c_word[WORD_W-1:8]};
    assign w_skip_dec = c_skip - LEN_W'(1);
    assign w_id       = w_shift[ID_W-1:0];
    assign w_len      = w_shift[WORD_W-1:ID_W];
    assign w_len_pad  = c_pad ? ((w_len + LEN_W'(3)) & 16'hFFFC) : w_len;

    always_comb begin
        n_phase  = c_phase;
        n_pos    = c_pos;
        n_word   = c_word;
        n_skip   = c_skip;
        n_pad    = c_pad;
        n_emit   = 1'b0;
        n_status = ST_FOUND;
        n_offset = '0;
        n_length = '0;

        unique case (c_phase)
            PH_MAGIC: begin
                if (w_eff < CMP_W'(WORD_BYTES)) begin
                    n_emit   = 1'b1;
                    n_status = ST_BAD_HDR;
                    n_phase  = PH_DONE;
                end else begin
                    n_word = w_shift;
                    n_pos  = w_pos_inc[POS_W-1:0];
                    n_skip = w_skip_dec;
                    if (w_skip_dec == '0) begin
                        if (w_shift == r_magic_packed || w_shift == r_magic_aligned
                                || w_shift == r_magic_plain) begin
                            n_pad = (w_shift != r_magic_packed) && (w_shift == r_magic_aligned);
                            if (w_hdr_end) begin
                                n_emit   = 1'b1;
                                n_status = ST_END;
                                n_phase  = PH_DONE;
                            end else begin
                                n_phase = PH_HEADER;
                                n_skip  = WORD_BYTES;
                            end
                        end else if (w_shift == r_magic_crc
                                && w_eff >= CMP_W'(CRC_HDR_BYTES)) begin
                            n_pad   = 1'b0;
                            n_phase = PH_CRC;
                            n_skip  = WORD_BYTES;
                        end else begin
                            n_emit   = 1'b1;
                            n_status = ST_BAD_HDR;
                            n_phase  = PH_DONE;
                        end
                    end
                end
            end
            PH_CRC, PH_SKIP: begin
                n_pos  = w_pos_inc[POS_W-1:0];
                n_skip = w_skip_dec;
                if (w_skip_dec == '0) begin
                    if (w_hdr_end) begin
                        n_emit   = 1'b1;
                        n_status = ST_END;
                        n_phase  = PH_DONE;
                    end else begin
                        n_phase = PH_HEADER;
                        n_skip  = WORD_BYTES;
                    end
                end
            end
            PH_HEADER: begin
                n_word = w_shift;
                n_pos  = w_pos_inc[POS_W-1:0];
                n_skip = w_skip_dec;
                if (w_skip_dec == '0) begin
                    if (w_id == r_end_id) begin
                        n_emit   = 1'b1;
                        n_status = ST_TERM;
                        n_phase  = PH_DONE;
                    end else if (w_left < {{(CMP_W-LEN_W){1'b0}}, w_len_pad}) begin
                        n_emit   = 1'b1;
                        n_status = ST_OVERRUN;
                        n_phase  = PH_DONE;
                    end else if (w_id == r_wanted_id) begin
                        n_emit   = 1'b1;
                        n_status = ST_FOUND;
                        n_offset = w_pos_inc[OFFS_W-1:0];
                        n_length = w_len_pad;
                        n_phase  = PH_DONE;
                    end else if (w_len_pad == '0) begin
                        // An empty body is skipped at once: the next header follows unless the blob ends.
                        if (w_hdr_end) begin
                            n_emit   = 1'b1;
                            n_status = ST_END;
                            n_phase  = PH_DONE;
                        end else begin
                            n_skip = WORD_BYTES;
                        end
                    end else begin
                        n_phase = PH_SKIP;
                        n_skip  = w_len_pad;
                    end
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_plain   <= RST_MAGIC_PLAIN;
            r_magic_packed  <= RST_MAGIC_PACKED;
            r_magic_aligned <= RST_MAGIC_ALIGNED;
            r_magic_crc     <= RST_MAGIC_CRC;
            r_end_id        <= RST_END_ID;
            r_wanted_id     <= RST_WANTED_ID;
            r_blob_len      <= RST_BLOB_LEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MAGIC_PLAIN:   r_magic_plain   <= i_cfg_data;
                CFG_MAGIC_PACKED:  r_magic_packed  <= i_cfg_data;
                CFG_MAGIC_ALIGNED: r_magic_aligned <= i_cfg_data;
                CFG_MAGIC_CRC:     r_magic_crc     <= i_cfg_data;
                CFG_END_ID:        r_end_id        <= i_cfg_data[ID_W-1:0];
                CFG_WANTED_ID:     r_wanted_id     <= i_cfg_data[ID_W-1:0];
                CFG_BLOB_LEN:      r_blob_len      <= i_cfg_data[BLOB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready) begin
            r_byte  <= i_in.data_byte;
            r_first <= i_in.first_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_MAGIC;
            r_pos       <= '0;
            r_word      <= '0;
            r_skip      <= WORD_BYTES;
            r_pad       <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_proc) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_word  <= n_word;
                r_skip  <= n_skip;
                r_pad   <= n_pad;
            end
            if (w_proc && n_emit) begin
                r_out_valid <= 1'b1;
                r_status    <= n_status;
                r_offset    <= n_offset;
                r_length    <= n_length;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.search_status = r_status;
    assign o_res.body_offset   = r_offset;
    assign o_res.body_length   = r_length;

    // A search that has given its result stays finished until a restart.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && n_emit) |=> (r_phase == PH_DONE && r_out_valid))
        else $error("result given without finishing the search");

    // Only a found tag reports an offset or a length.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_FOUND) |-> (r_offset == '0 && r_length == '0))
        else $error("failed search reports a nonzero offset or length");

    // Every active phase still has bytes to count down.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_DONE) |-> (r_skip != '0))
        else $error("skip counter reached zero outside the done phase");

    // A new result only enters when the result register is free or drained.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> $stable(r_status) && r_out_valid)
        else $error("pending result overwritten");

endmodule
`default_nettype wire
